// ===== design/plac_pkg.sv =====
// ---------------------------------------------------------------------------
// plac_pkg: shared constants for the Phong light accumulator
// Widths of the packed fields, the shared multiplier and the iterative units.
// ---------------------------------------------------------------------------
package plac_pkg;

    localparam int CW       = 16;           // one Q8.8 component
    localparam int IN_W     = 3 * CW;       // packed xyz vector
    localparam int COLOR_W  = 24;
    localparam int CH_W     = 8;
    localparam int AMB_W    = 9;
    localparam logic [AMB_W-1:0] AMB_RESET = 9'd64;

    // working vector before scaling to unit length
    localparam int VEC_W    = 42;
    localparam int MAG_BITS = 16;           // magnitudes kept below 2^16 before length

    // shared multiplier
    localparam int MA_W     = 24;
    localparam int MB_W     = 18;
    localparam int PROD_W   = MA_W + MB_W;

    localparam int ACC_W    = 36;
    localparam int UNIT_W   = 16;           // Q2.14 unit vector component
    localparam int UNIT_SHIFT = 28;

    // square root and divider
    localparam int RAD_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int NUM_W    = 16;
    localparam int QUO_W    = 15;
    localparam int REM_W    = ROOT_W + QUO_W - 1;
    localparam int QCNT_W   = 4;

    // diffuse and specular
    localparam int DIF_W    = 9;
    localparam logic [DIF_W-1:0] DIF_MAX = 9'd256;
    localparam int SPEC_W   = 17;
    localparam logic [SPEC_W-1:0] SPEC_ONE = 17'd65536;
    localparam int POW_BITS = 9;
    localparam logic [POW_BITS-1:0] SPEC_POWER = 9'd500;
    localparam int GAIN_W   = 24;           // 200 * specular
    localparam int T_W      = 27;
    localparam logic [CH_W-1:0] CHAN_MAX = 8'd255;

endpackage

// ===== design/plac_if.sv =====
// ---------------------------------------------------------------------------
// plac_if: channel interfaces of the Phong light accumulator
// Light request channel, pixel result channel and ambient register write.
// ---------------------------------------------------------------------------
interface plac_light_if
    import plac_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [IN_W-1:0]    surface_point;
    logic [IN_W-1:0]    light_position;
    logic [IN_W-1:0]    surface_normal;
    logic [IN_W-1:0]    ray_direction;
    logic [COLOR_W-1:0] object_color;
    logic               no_normal;
    logic               last_light;

    modport source (output valid, surface_point, light_position, surface_normal,
                    ray_direction, object_color, no_normal, last_light, input ready);
    modport sink   (input valid, surface_point, light_position, surface_normal,
                    ray_direction, object_color, no_normal, last_light, output ready);
endinterface

interface plac_pixel_if
    import plac_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;

    modport source (output valid, pixel_color, input ready);
    modport sink   (input valid, pixel_color, output ready);
endinterface

interface plac_cfg_if
    import plac_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [AMB_W-1:0] ambient_level;

    modport source (output valid, ambient_level, input ready);
    modport sink   (input valid, ambient_level, output ready);
endinterface

// ===== design/plac_mul.sv =====
// ---------------------------------------------------------------------------
// plac_mul: shared signed multiplier
// One 24x18 signed product per cycle, registered at the output.
// ---------------------------------------------------------------------------
module plac_mul
    import plac_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MA_W-1:0]   a,
    input  logic signed [MB_W-1:0]   b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== design/plac_root.sv =====
// ---------------------------------------------------------------------------
// plac_root: iterative integer square root
// Two radicand bits per cycle, giving floor(sqrt(x)).
// ---------------------------------------------------------------------------
module plac_root
    import plac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [RAD_W-1:0] x_reg;
    logic [RAD_W-1:0] res_reg;
    logic [RAD_W-1:0] bit_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [RAD_W-1:0] trial;
    logic             fits;

    assign trial = res_reg + bit_reg;
    assign fits  = x_reg >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && bit_reg[0];
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg[0])
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= RAD_W'(1) << (RAD_W - 2);
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                x_reg   <= x_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// ===== design/plac_div.sv =====
// ---------------------------------------------------------------------------
// plac_div: iterative restoring divider
// Computes (num << 28) / den, one quotient bit per cycle, 15 bits.
// ---------------------------------------------------------------------------
module plac_div
    import plac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [ROOT_W-1:0] den,
    output logic              done,
    output logic [QUO_W-1:0]  quot
);

    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  dv_reg;
    logic [QUO_W-1:0]  q_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              take;

    assign take = rem_reg >= dv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= QCNT_W'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= REM_W'({num, UNIT_SHIFT'(0)});
            dv_reg  <= REM_W'({den, (QUO_W - 1)'(0)});
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (take)
                rem_reg <= rem_reg - dv_reg;
            q_reg  <= {q_reg[QUO_W-2:0], take};
            dv_reg <= dv_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== design/phong_light_accumulator.sv =====
// ---------------------------------------------------------------------------
// phong_light_accumulator: per-light Phong shading with saturating sums
// Sequencer around one shared multiplier, a square root and a divider.
// ---------------------------------------------------------------------------
// Usage
//   light_in : one request per light of a shaded point (geometry, color,
//              no_normal, last_light). ready is high only while idle.
//   pixel_out: one packed color after the request that carries last_light.
//   cfg      : writes ambient_level; always ready, write only while idle.
// Sequence
//   A lit light halves a vector until each component is below 2^16: never
//   the light vector, up to 22 times the reflected vector. Each unit-vector
//   pass is a square root and three divides; the power-500 chain is 15
//   products on the shared multiplier. A zero-length vector skips its square
//   root and divides. A no_normal light goes straight to the accumulate step.
// Reset
//   Channel sums clear to zero, ambient_level returns to 64, no result pending.
// Stall
//   The result sits in an output register; the next light is taken while it
//   waits. A later last_light holds in the final step until that slot frees.
// ---------------------------------------------------------------------------
module phong_light_accumulator
    import plac_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    plac_light_if.sink   light_in,
    plac_pixel_if.source pixel_out,
    plac_cfg_if.sink     cfg
);

    typedef enum logic [20:0] {
        ST_IDLE     = 21'h000001,
        ST_HALVE    = 21'h000002,
        ST_SQ       = 21'h000004,
        ST_SQ_ADD   = 21'h000008,
        ST_ROOT_GO  = 21'h000010,
        ST_ROOT_WT  = 21'h000020,
        ST_DIV_GO   = 21'h000040,
        ST_DIV_WT   = 21'h000080,
        ST_DOT      = 21'h000100,
        ST_DOT_ADD  = 21'h000200,
        ST_DOT_END  = 21'h000400,
        ST_REFL     = 21'h000800,
        ST_REFL_ADD = 21'h001000,
        ST_POW_SEL  = 21'h002000,
        ST_POW_MR   = 21'h004000,
        ST_POW_MR_A = 21'h008000,
        ST_POW_SQ   = 21'h010000,
        ST_POW_SQ_A = 21'h020000,
        ST_CHAN     = 21'h040000,
        ST_CHAN_ADD = 21'h080000,
        ST_ACCUM    = 21'h100000
    } state_t;

    // control
    state_t              state_reg, state_next;
    logic [1:0]          idx_reg, idx_next;
    logic [QCNT_W-1:0]   bit_idx_reg, bit_idx_next;
    logic                phase_reg, phase_next;
    logic [AMB_W-1:0]    amb_reg;
    logic [CH_W-1:0]     sum_reg [3];
    logic [CH_W-1:0]     sum_next [3];
    logic                out_valid_reg, out_valid_next;

    // payload
    logic signed [CW-1:0]     n_reg [3];
    logic signed [CW-1:0]     n_next [3];
    logic signed [CW-1:0]     d_reg [3];
    logic signed [CW-1:0]     d_next [3];
    logic [CH_W-1:0]          ch_reg [3];
    logic [CH_W-1:0]          ch_next [3];
    logic signed [VEC_W-1:0]  vec_reg [3];
    logic signed [VEC_W-1:0]  vec_next [3];
    logic signed [UNIT_W-1:0] unit_reg [3];
    logic signed [UNIT_W-1:0] unit_next [3];
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [DIF_W-1:0]         dif_reg, dif_next;
    logic signed [MA_W-1:0]   k_reg, k_next;
    logic [SPEC_W-1:0]        pres_reg, pres_next;
    logic [SPEC_W-1:0]        pb_reg, pb_next;
    logic                     last_reg, last_next;
    logic [COLOR_W-1:0]       out_color_reg, out_color_next;

    // shared units
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     root_start, root_done;
    logic [ROOT_W-1:0]        root;
    logic                     div_start, div_done;
    logic [QUO_W-1:0]         quot;

    // helpers
    logic                     accept;
    logic                     out_free;
    logic signed [VEC_W-1:0]  vmag [3];
    logic                     too_big;
    logic [GAIN_W-1:0]        spec_gain;
    logic [T_W-1:0]           chan_t;
    logic [CH_W:0]            sat_sum [3];
    logic [RAD_W-1:0]         radicand;

    plac_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    plac_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    plac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (vmag[idx_reg][NUM_W-1:0]),
        .den   (root),
        .done  (div_done),
        .quot  (quot)
    );

    assign light_in.ready      = (state_reg == ST_IDLE);
    assign accept              = light_in.valid && light_in.ready;
    assign cfg.ready           = 1'b1;
    assign out_free            = !out_valid_reg || pixel_out.ready;
    assign pixel_out.valid     = out_valid_reg;
    assign pixel_out.pixel_color = out_color_reg;

    assign radicand  = RAD_W'({acc_reg[ACC_W-2:0], UNIT_SHIFT'(0)});
    assign spec_gain = (GAIN_W'(pres_reg) << 7) + (GAIN_W'(pres_reg) << 6)
                     + (GAIN_W'(pres_reg) << 3);
    assign chan_t    = T_W'({prod[MB_W-1:0], 8'd0}) + T_W'(spec_gain);

    always_comb
    begin
        too_big = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            vmag[i] = vec_reg[i][VEC_W-1] ? -vec_reg[i] : vec_reg[i];
            if (vmag[i][VEC_W-1:MAG_BITS] != '0)
                too_big = 1'b1;
            sat_sum[i] = {1'b0, sum_reg[i]} + {1'b0, ch_reg[i]};
        end
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQ:
            begin
                mul_a = MA_W'($signed(vec_reg[idx_reg][MAG_BITS:0]));
                mul_b = MB_W'($signed(vec_reg[idx_reg][MAG_BITS:0]));
            end
            ST_DOT:
            begin
                mul_a = MA_W'(unit_reg[idx_reg]);
                mul_b = phase_reg ? MB_W'(d_reg[idx_reg]) : MB_W'(n_reg[idx_reg]);
            end
            ST_REFL:
            begin
                mul_a = k_reg;
                mul_b = MB_W'(n_reg[idx_reg]);
            end
            ST_POW_MR:
            begin
                mul_a = $signed(MA_W'(pres_reg));
                mul_b = $signed(MB_W'(pb_reg));
            end
            ST_POW_SQ:
            begin
                mul_a = $signed(MA_W'(pb_reg));
                mul_b = $signed(MB_W'(pb_reg));
            end
            ST_CHAN:
            begin
                mul_a = $signed(MA_W'(ch_reg[idx_reg]));
                mul_b = $signed(MB_W'(dif_reg) + MB_W'(amb_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        bit_idx_next   = bit_idx_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !pixel_out.ready;
        acc_next       = acc_reg;
        dif_next       = dif_reg;
        k_next         = k_reg;
        pres_next      = pres_reg;
        pb_next        = pb_reg;
        last_next      = last_reg;
        out_color_next = out_color_reg;
        root_start     = 1'b0;
        div_start      = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i]  = sum_reg[i];
            n_next[i]    = n_reg[i];
            d_next[i]    = d_reg[i];
            ch_next[i]   = ch_reg[i];
            vec_next[i]  = vec_reg[i];
            unit_next[i] = unit_reg[i];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        n_next[i]   = light_in.surface_normal[CW*(2-i) +: CW];
                        d_next[i]   = light_in.ray_direction[CW*(2-i) +: CW];
                        ch_next[i]  = light_in.object_color[CH_W*(2-i) +: CH_W];
                        vec_next[i] =
                            VEC_W'($signed(light_in.light_position[CW*(2-i) +: CW]))
                          - VEC_W'($signed(light_in.surface_point[CW*(2-i) +: CW]));
                    end
                    last_next  = light_in.last_light;
                    phase_next = 1'b0;
                    state_next = light_in.no_normal ? ST_ACCUM : ST_HALVE;
                end
            end
            ST_HALVE:
            begin
                if (too_big)
                begin
                    // halve with truncation toward zero
                    for (int i = 0; i < 3; i++)
                        vec_next[i] = (vec_reg[i]
                                     + $signed(VEC_W'(vec_reg[i][VEC_W-1]))) >>> 1;
                end
                else
                begin
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                state_next = ST_SQ_ADD;
            end
            ST_SQ_ADD:
            begin
                acc_next = acc_reg + ACC_W'(prod);
                if (idx_reg == 2'd2)
                    state_next = ST_ROOT_GO;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_ROOT_GO:
            begin
                idx_next = '0;
                if (acc_reg == '0)
                begin
                    // zero length: unit vector is zero
                    for (int i = 0; i < 3; i++)
                        unit_next[i] = '0;
                    state_next = ST_DOT;
                end
                else
                begin
                    root_start = 1'b1;
                    state_next = ST_ROOT_WT;
                end
            end
            ST_ROOT_WT:
            begin
                if (root_done)
                    state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WT;
            end
            ST_DIV_WT:
            begin
                if (div_done)
                begin
                    unit_next[idx_reg] = vec_reg[idx_reg][VEC_W-1]
                                       ? -UNIT_W'(quot) : UNIT_W'(quot);
                    if (idx_reg == 2'd2)
                    begin
                        idx_next   = '0;
                        acc_next   = '0;
                        state_next = ST_DOT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_DOT:
            begin
                state_next = ST_DOT_ADD;
            end
            ST_DOT_ADD:
            begin
                acc_next = acc_reg + ACC_W'(prod);
                if (idx_reg == 2'd2)
                    state_next = ST_DOT_END;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_DOT;
                end
            end
            ST_DOT_END:
            begin
                idx_next = '0;
                if (!phase_reg)
                begin
                    if (acc_reg <= 0)
                        dif_next = '0;
                    else if (acc_reg[ACC_W-1:14] > (ACC_W-14)'(DIF_MAX))
                        dif_next = DIF_MAX;
                    else
                        dif_next = acc_reg[14 +: DIF_W];
                    // divide by 256 toward zero
                    k_next = MA_W'((acc_reg + (acc_reg[ACC_W-1] ? ACC_W'(255) : '0))
                                   >>> 8);
                    state_next = ST_REFL;
                end
                else
                begin
                    if (acc_reg <= 0)
                        pb_next = '0;
                    else if (acc_reg[ACC_W-1:6] > (ACC_W-6)'(SPEC_ONE))
                        pb_next = SPEC_ONE;
                    else
                        pb_next = acc_reg[6 +: SPEC_W];
                    pres_next    = SPEC_ONE;
                    bit_idx_next = '0;
                    state_next   = ST_POW_SEL;
                end
            end
            ST_REFL:
            begin
                state_next = ST_REFL_ADD;
            end
            ST_REFL_ADD:
            begin
                vec_next[idx_reg] = (VEC_W'(unit_reg[idx_reg]) <<< 8)
                                  - VEC_W'(prod <<< 1);
                if (idx_reg == 2'd2)
                begin
                    phase_next = 1'b1;
                    state_next = ST_HALVE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_REFL;
                end
            end
            ST_POW_SEL:
            begin
                priority if (bit_idx_reg == QCNT_W'(POW_BITS))
                begin
                    idx_next   = '0;
                    state_next = ST_CHAN;
                end
                else if (SPEC_POWER[bit_idx_reg])
                    state_next = ST_POW_MR;
                else
                    state_next = ST_POW_SQ;
            end
            ST_POW_MR:
            begin
                state_next = ST_POW_MR_A;
            end
            ST_POW_MR_A:
            begin
                pres_next  = prod[16 +: SPEC_W];
                state_next = ST_POW_SQ;
            end
            ST_POW_SQ:
            begin
                state_next = ST_POW_SQ_A;
            end
            ST_POW_SQ_A:
            begin
                pb_next      = prod[16 +: SPEC_W];
                bit_idx_next = bit_idx_reg + 1'b1;
                state_next   = ST_POW_SEL;
            end
            ST_CHAN:
            begin
                state_next = ST_CHAN_ADD;
            end
            ST_CHAN_ADD:
            begin
                ch_next[idx_reg] = (chan_t[T_W-1:16] > (T_W-16)'(CHAN_MAX))
                                 ? CHAN_MAX : chan_t[16 +: CH_W];
                if (idx_reg == 2'd2)
                    state_next = ST_ACCUM;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_CHAN;
                end
            end
            ST_ACCUM:
            begin
                if (!last_reg)
                begin
                    for (int i = 0; i < 3; i++)
                        sum_next[i] = sat_sum[i][CH_W] ? CHAN_MAX : sat_sum[i][CH_W-1:0];
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        out_color_next[CH_W*(2-i) +: CH_W] =
                            sat_sum[i][CH_W] ? CHAN_MAX : sat_sum[i][CH_W-1:0];
                        sum_next[i] = '0;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            bit_idx_reg   <= '0;
            phase_reg     <= 1'b0;
            amb_reg       <= AMB_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                sum_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            bit_idx_reg   <= bit_idx_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
                amb_reg <= cfg.ambient_level;
            for (int i = 0; i < 3; i++)
                sum_reg[i] <= sum_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        dif_reg       <= dif_next;
        k_reg         <= k_next;
        pres_reg      <= pres_next;
        pb_reg        <= pb_next;
        last_reg      <= last_next;
        out_color_reg <= out_color_next;
        for (int i = 0; i < 3; i++)
        begin
            n_reg[i]    <= n_next[i];
            d_reg[i]    <= d_next[i];
            ch_reg[i]   <= ch_next[i];
            vec_reg[i]  <= vec_next[i];
            unit_reg[i] <= unit_next[i];
        end
    end

endmodule

// ===== design/plac_checker.sv =====
// ---------------------------------------------------------------------------
// plac_checker: port-level checks for the Phong light accumulator
// Watches the light and pixel channels of the top level.
// ---------------------------------------------------------------------------
module plac_checker
    import plac_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [COLOR_W-1:0] pixel_color
);

    // one light at a time: busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("light channel ready right after a request");

    // a result taken while idle leaves nothing behind it
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && in_ready |=> !out_valid)
        else $error("second pixel result without a new light");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("pixel result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_color))
        else $error("pixel result changed while stalled");

endmodule

bind phong_light_accumulator plac_checker u_plac_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (light_in.valid),
    .in_ready    (light_in.ready),
    .out_valid   (pixel_out.valid),
    .out_ready   (pixel_out.ready),
    .pixel_color (pixel_out.pixel_color)
);

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for phong_light_accumulator
// Directed light table, then random points of one to four lights, checked
// against a fixed-point shading predictor, with random gaps and output stalls.
// ---------------------------------------------------------------------------
module tb_top;
    import plac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM  = 1030;
    localparam int  MAX_GAP   = 18;
    localparam int  SETTLE    = 400;        // longest lit light plus margin
    localparam longint LIMIT  = 2000000;

    typedef longint vec3_t [3];

    typedef struct {
        logic [IN_W-1:0]    pt;
        logic [IN_W-1:0]    lp;
        logic [IN_W-1:0]    nrm;
        logic [IN_W-1:0]    ray;
        logic [COLOR_W-1:0] col;
        logic               nn;
        logic               last;
        logic               fixed_exp;
        logic [COLOR_W-1:0] exp_color;
    } light_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    plac_light_if lin();
    plac_pixel_if pout();
    plac_cfg_if   cfg();

    phong_light_accumulator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .light_in  (lin),
        .pixel_out (pout),
        .cfg       (cfg)
    );

    always #6 clk = ~clk;

    // shading state mirror
    logic [AMB_W-1:0]   amb_now;
    logic [CH_W-1:0]    sum_r, sum_g, sum_b;
    logic [COLOR_W-1:0] pixel_q[$];

    int     n_err = 0;
    int     n_pixels = 0;
    int     n_lights = 0;
    int     n_spec = 0;
    longint cyc = 0;
    bit     no_stall_mode = 0;

    light_req_t dir_tab[16];

    function automatic longint comp(input logic [IN_W-1:0] f, input int idx);
        logic [CW-1:0] c;
        c = f[idx*CW +: CW];
        return longint'($signed(c));
    endfunction

    function automatic longint unsigned root64(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic vec3_t unit_of(input vec3_t v);
        vec3_t a, u;
        longint unsigned len2, s;
        a = v;
        while ((a[0] >= 65536 || a[0] <= -65536) || (a[1] >= 65536 || a[1] <= -65536) ||
               (a[2] >= 65536 || a[2] <= -65536))
            for (int i = 0; i < 3; i++)
                a[i] = a[i] / 2;
        len2 = 0;
        for (int i = 0; i < 3; i++)
            len2 += longint'(a[i] * a[i]);
        if (len2 == 0) begin
            u[0] = 0; u[1] = 0; u[2] = 0;
            return u;
        end
        s = root64(len2 << 28);
        for (int i = 0; i < 3; i++)
            u[i] = (a[i] * 268435456) / longint'(s);
        return u;
    endfunction

    function automatic longint unsigned spec_pow(input longint unsigned p);
        longint unsigned acc, b;
        logic [POW_BITS-1:0] e;
        acc = 65536;
        b = p;
        e = SPEC_POWER;
        for (int i = 0; i < POW_BITS; i++) begin
            if (e[i])
                acc = (acc * b) >> 16;
            b = (b * b) >> 16;
        end
        return acc;
    endfunction

    // updates the channel sums; returns 1 with the pixel on the last light
    function automatic bit shade_light(input light_req_t q, output logic [COLOR_W-1:0] px);
        longint unsigned ch[3], dif, p, spec, t;
        vec3_t lv, lu, nv, dv, rv, ru;
        longint dd, k, ss;
        ch[0] = q.col[23:16];
        ch[1] = q.col[15:8];
        ch[2] = q.col[7:0];
        px = '0;
        if (!q.nn) begin
            for (int i = 0; i < 3; i++) begin
                lv[i] = comp(q.lp, 2-i) - comp(q.pt, 2-i);
                nv[i] = comp(q.nrm, 2-i);
                dv[i] = comp(q.ray, 2-i);
            end
            lu = unit_of(lv);
            dd = nv[0]*lu[0] + nv[1]*lu[1] + nv[2]*lu[2];
            if (dd <= 0)
                dif = 0;
            else begin
                dif = longint'(dd) >>> 14;
                if (dif > DIF_MAX)
                    dif = DIF_MAX;
            end
            k = dd / 256;
            for (int i = 0; i < 3; i++)
                rv[i] = lu[i]*256 - 2*nv[i]*k;
            ru = unit_of(rv);
            ss = dv[0]*ru[0] + dv[1]*ru[1] + dv[2]*ru[2];
            if (ss <= 0)
                p = 0;
            else begin
                p = ss >>> 6;
                if (p > SPEC_ONE)
                    p = SPEC_ONE;
            end
            spec = spec_pow(p);
            if (spec != 0)
                n_spec++;
            for (int i = 0; i < 3; i++) begin
                t = (((ch[i] * (dif + amb_now)) << 8) + 200 * spec) >> 16;
                ch[i] = (t > CHAN_MAX) ? CHAN_MAX : t;
            end
        end
        sum_r = (sum_r + ch[0] > CHAN_MAX) ? CHAN_MAX : CH_W'(sum_r + ch[0]);
        sum_g = (sum_g + ch[1] > CHAN_MAX) ? CHAN_MAX : CH_W'(sum_g + ch[1]);
        sum_b = (sum_b + ch[2] > CHAN_MAX) ? CHAN_MAX : CH_W'(sum_b + ch[2]);
        if (q.last) begin
            px = {sum_r, sum_g, sum_b};
            sum_r = '0; sum_g = '0; sum_b = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [IN_W-1:0] vec(input int x, input int y, input int z);
        logic [CW-1:0] a, b, c;
        a = CW'(x); b = CW'(y); c = CW'(z);
        return {a, b, c};
    endfunction

    function automatic logic [IN_W-1:0] rand_vec();
        case ($urandom_range(0, 3))
            0: return IN_W'({$urandom, $urandom});
            1: return vec($urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048,
                          $urandom_range(0, 4096) - 2048);
            default: return vec($urandom_range(0, 1024) - 512, $urandom_range(0, 1024) - 512,
                                $urandom_range(0, 1024) - 512);
        endcase
    endfunction

    function automatic light_req_t rand_light(input bit last);
        light_req_t q;
        int nz, jx, jy;
        q.pt  = rand_vec();
        q.lp  = rand_vec();
        q.nrm = rand_vec();
        q.ray = rand_vec();
        // some lights set up near a mirror bounce so the highlight shows
        if ($urandom_range(0, 3) == 0) begin
            nz = $urandom_range(64, 512);
            jx = $urandom_range(0, 6) - 3;
            jy = $urandom_range(0, 6) - 3;
            q.pt  = vec($urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32, 0);
            q.lp  = vec(int'(comp(q.pt, 2)), int'(comp(q.pt, 1)), $urandom_range(1, 2000));
            q.nrm = vec(jx, jy, nz);
            q.ray = vec(jy, jx, -$urandom_range(1, 2000));
        end
        q.col = COLOR_W'($urandom);
        q.nn  = ($urandom_range(0, 7) == 0);
        q.last = last;
        q.fixed_exp = 1'b0;
        q.exp_color = '0;
        return q;
    endfunction

    function automatic int draw_gap();
        return no_stall_mode ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic send_light(input light_req_t q);
        int gap;
        logic [COLOR_W-1:0] px;
        gap = draw_gap();
        if (gap > 0) begin
            lin.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        lin.valid          <= 1'b1;
        lin.surface_point  <= q.pt;
        lin.light_position <= q.lp;
        lin.surface_normal <= q.nrm;
        lin.ray_direction  <= q.ray;
        lin.object_color   <= q.col;
        lin.no_normal      <= q.nn;
        lin.last_light     <= q.last;
        @(posedge clk);
        while (!lin.ready)
            @(posedge clk);
        n_lights++;
        if (shade_light(q, px))
            pixel_q.push_back(q.fixed_exp ? q.exp_color : px);
    endtask

    task automatic wait_idle();
        lin.valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_ambient(input logic [AMB_W-1:0] v);
        cfg.valid         <= 1'b1;
        cfg.ambient_level <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        amb_now = v;
        @(posedge clk);
    endtask

    // result side: random stall before each pixel, compare in order
    int stall_left = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (pout.valid && pout.ready) begin
                n_pixels++;
                if (pixel_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected pixel %06h", pout.pixel_color);
                end
                else if (pout.pixel_color !== pixel_q[0]) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("pixel mismatch: exp %06h got %06h",
                                 pixel_q[0], pout.pixel_color);
                    void'(pixel_q.pop_front());
                end
                else
                    void'(pixel_q.pop_front());
                stall_left <= draw_gap();
                pout.ready <= no_stall_mode;
            end
            else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                pout.ready <= (stall_left == 1);
            end
            else
                pout.ready <= 1'b1;
        end
        else
            pout.ready <= 1'b1;
    end

    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        light_req_t q;
        int n_pts, n_in_pt;

        lin.valid <= 1'b0;
        lin.surface_point <= '0;
        lin.light_position <= '0;
        lin.surface_normal <= '0;
        lin.ray_direction <= '0;
        lin.object_color <= '0;
        lin.no_normal <= 1'b0;
        lin.last_light <= 1'b0;
        cfg.valid <= 1'b0;
        cfg.ambient_level <= '0;
        amb_now = AMB_RESET;
        sum_r = '0; sum_g = '0; sum_b = '0;

        // pt, light, normal, ray, color, no_normal, last, fixed?, expected
        dir_tab[0]  = '{'0, '0, '0, '0, 24'hffffff, 1, 1, 1, 24'hffffff};
        dir_tab[1]  = '{'0, '0, '0, '0, 24'h800000, 1, 0, 0, '0};
        dir_tab[2]  = '{'0, '0, '0, '0, 24'h900102, 1, 1, 1, 24'hff0102};
        dir_tab[3]  = '{'0, '0, '0, '0, 24'h000000, 1, 1, 1, 24'h000000};
        // head-on mirror bounce, black object: highlight only
        dir_tab[4]  = '{'0, vec(0, 0, 256), vec(0, 0, 256), vec(0, 0, -256),
                        24'h000000, 0, 1, 1, 24'hc8c8c8};
        // light at the point itself: ambient only
        dir_tab[5]  = '{vec(5, -7, 9), vec(5, -7, 9), vec(0, 0, 256), vec(1, 2, 3),
                        24'hffffff, 0, 1, 1, 24'h3f3f3f};
        dir_tab[6]  = '{'0, vec(0, 0, 256), '0, vec(0, 0, 256), 24'h102030, 0, 1, 0, '0};
        dir_tab[7]  = '{'1, '1, '1, '1, 24'hffffff, 0, 1, 0, '0};
        dir_tab[8]  = '{vec(-32768, -32768, -32768), vec(32767, 32767, 32767),
                        vec(32767, 32767, 32767), vec(-32768, -32768, -32768),
                        24'hffffff, 0, 1, 0, '0};
        dir_tab[9]  = '{vec(32767, -32768, 0), vec(-32768, 32767, 0), vec(-32768, 0, 32767),
                        vec(0, 32767, -32768), 24'h55aa55, 0, 1, 0, '0};
        dir_tab[10] = '{'0, vec(0, 256, 256), vec(0, 0, 256), vec(0, 1, 1),
                        24'h804020, 0, 0, 0, '0};
        dir_tab[11] = '{'0, vec(256, 0, 10), vec(0, 0, 256), vec(-256, 0, 10),
                        24'hc0c0c0, 0, 0, 0, '0};
        dir_tab[12] = '{'0, '0, '0, '0, 24'h7f7f7f, 1, 1, 0, '0};
        dir_tab[13] = '{'0, vec(0, 0, -256), vec(0, 0, 256), vec(0, 0, 256),
                        24'hffffff, 0, 1, 0, '0};
        dir_tab[14] = '{vec(100, 100, 100), vec(100, 100, 612), vec(0, 0, 128),
                        vec(0, 0, -128), 24'haabbcc, 0, 1, 0, '0};
        dir_tab[15] = '{'0, vec(0, 300, 400), vec(0, 0, 256), vec(0, 300, -400),
                        24'h0f0f0f, 0, 1, 0, '0};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (dir_tab[i])
            send_light(dir_tab[i]);
        wait_idle();

        n_pts = 0;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_ambient(9'd0);
                1: write_ambient(9'd256);
                2: write_ambient(AMB_RESET);
                default: write_ambient(AMB_W'($urandom_range(0, 256)));
            endcase
            while (n_lights < 16 + (ph + 1) * (N_RANDOM / 5)) begin
                if ($urandom_range(0, 9) == 0)
                    no_stall_mode = ~no_stall_mode;
                n_in_pt = $urandom_range(1, 4);
                for (int j = 0; j < n_in_pt; j++) begin
                    q = rand_light(j == n_in_pt - 1);
                    send_light(q);
                end
                n_pts++;
            end
            wait_idle();
        end

        n_err += pixel_q.size();
        $display("%0d lights over %0d random points, %0d pixels checked, %0d lit highlights",
                 n_lights, n_pts, n_pixels, n_spec);
        $display("ambient levels 0, 64, 256 and random; %0d errors", n_err);
        if (n_err == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/plac_pkg.sv
design/plac_if.sv
design/plac_mul.sv
design/plac_root.sv
design/plac_div.sv
design/phong_light_accumulator.sv
design/plac_checker.sv
sim/tb_top.sv
